// ----- design/rbst_pkg.sv -----
// Shared types and constants for the ray/box slab test pipeline.
package rbst_pkg;

  localparam int NumAxes  = 3;
  localparam int NumLanes = 6;   // lanes 0..2 lower corner, 3..5 upper corner
  localparam int QBits    = 32;
  localparam int DivSteps = 32;  // one quotient bit per stage
  localparam int CoordW   = 32;
  localparam int DiffW    = 33;
  localparam int WideW    = 34;  // room for the unbounded slab marks

  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX    = 3'd3;
  localparam logic [2:0] RegDirY    = 3'd4;
  localparam logic [2:0] RegDirZ    = 3'd5;
  localparam logic [2:0] RegTLow    = 3'd6;
  localparam logic [2:0] RegTHigh   = 3'd7;

  localparam logic signed [WideW-1:0] PosUnbounded = 34'sh1_0000_0000;
  localparam logic signed [WideW-1:0] NegUnbounded = -34'sh1_0000_0000;
  localparam logic signed [WideW-1:0] QMax         = 34'sh0_7FFF_FFFF;
  localparam logic signed [WideW-1:0] QMin         = -34'sh0_8000_0000;

  // Ray setup as seen by the datapath
  typedef struct packed {
    logic [NumAxes-1:0][CoordW-1:0] org;
    logic [NumAxes-1:0][CoordW-1:0] dmag;  // |direction|
    logic [NumAxes-1:0]             dneg;
    logic [NumAxes-1:0]             dzero;
    logic [CoordW-1:0]              t_low;
    logic [CoordW-1:0]              t_high;
  } cfg_t;

  // One slab distance in flight through the divider
  typedef struct packed {
    logic              neg;    // sign of the quotient
    logic              dzero;  // direction component is zero
    logic              ovf;    // magnitude is at least 2^32
    logic [QBits-1:0]  rem;
    logic [QBits-1:0]  num;    // dividend bits not yet consumed
    logic [QBits-1:0]  q;
  } lane_t;

  typedef struct packed {
    logic                       valid;
    logic                       miss;
    logic [NumLanes-1:0][$bits(lane_t)-1:0] lane;
  } item_t;

endpackage

// ----- design/rbst_cfg.sv -----
// Configuration register file with APB-style access.
module rbst_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rbst_pkg::cfg_t      cfg
);
  import rbst_pkg::*;

  logic [7:0][31:0]               regs;
  logic [2:0]                     idx;
  logic                           wr;
  logic [31:0]                    wmag;
  logic [NumAxes-1:0][CoordW-1:0] dmag;
  logic [NumAxes-1:0]             dneg;
  logic [NumAxes-1:0]             dzero;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = regs[idx];
  assign wmag   = pwdata[31] ? (~pwdata + 32'd1) : pwdata;

  // register writes; direction magnitude is kept alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      regs  <= {32'h7FFF_FFFF, {7{32'h0}}};  // t_high sits in the top slot
      dmag  <= '0;
      dneg  <= '0;
      dzero <= '1;
    end else if (wr) begin
      regs[idx] <= pwdata;
      case (idx)
        RegDirX: begin
          dmag[0] <= wmag; dneg[0] <= pwdata[31]; dzero[0] <= (pwdata == '0);
        end
        RegDirY: begin
          dmag[1] <= wmag; dneg[1] <= pwdata[31]; dzero[1] <= (pwdata == '0);
        end
        RegDirZ: begin
          dmag[2] <= wmag; dneg[2] <= pwdata[31]; dzero[2] <= (pwdata == '0);
        end
        default: ;
      endcase
    end
  end

  assign cfg.dmag   = dmag;
  assign cfg.dneg   = dneg;
  assign cfg.dzero  = dzero;
  assign cfg.org[0] = regs[RegOriginX];
  assign cfg.org[1] = regs[RegOriginY];
  assign cfg.org[2] = regs[RegOriginZ];
  assign cfg.t_low  = regs[RegTLow];
  assign cfg.t_high = regs[RegTHigh];
endmodule

// ----- design/rbst_prep.sv -----
// Front stages: corner differences, early miss, divider setup.
module rbst_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_beat,
  input  logic [5:0][31:0]    corner,   // min x,y,z then max x,y,z
  input  rbst_pkg::cfg_t      cfg,
  output rbst_pkg::item_t     item
);
  import rbst_pkg::*;

  logic                          s1_valid;
  logic                          s1_miss;
  logic [NumLanes-1:0][DiffW-1:0] s1_diff;
  logic                          miss_next;
  logic [NumLanes-1:0][DiffW-1:0] diff_next;
  item_t                         item_next;

  // stage 1: differences and zero-direction containment
  always_comb begin
    miss_next = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      if (cfg.dzero[a] &&
          (($signed(cfg.org[a]) < $signed(corner[a])) ||
           ($signed(cfg.org[a]) > $signed(corner[a+NumAxes]))))
        miss_next = 1'b1;
    end
    for (int j = 0; j < NumLanes; j++)
      diff_next[j] = {corner[j][31], corner[j]} - {cfg.org[j%NumAxes][31], cfg.org[j%NumAxes]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_beat;
      s1_miss  <= miss_next;
      s1_diff  <= diff_next;
    end
  end

  // stage 2: magnitudes, overflow check, initial remainder
  always_comb begin
    lane_t        ln;
    logic [DiffW-1:0] mag;
    item_next.valid = s1_valid;
    item_next.miss  = s1_miss;
    for (int j = 0; j < NumLanes; j++) begin
      mag      = s1_diff[j][DiffW-1] ? (~s1_diff[j] + 33'd1) : s1_diff[j];
      ln.neg   = s1_diff[j][DiffW-1] ^ cfg.dneg[j%NumAxes];
      ln.dzero = cfg.dzero[j%NumAxes];
      ln.ovf   = {15'd0, mag} >= {cfg.dmag[j%NumAxes], 16'd0};
      ln.rem   = {15'd0, mag[32:16]};
      ln.num   = {mag[15:0], 16'd0};
      ln.q     = '0;
      item_next.lane[j] = ln;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (en) begin
      item <= item_next;
    end
  end
endmodule

// ----- design/rbst_div_step.sv -----
// One restoring-division stage: one quotient bit for all six lanes.
module rbst_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rbst_pkg::cfg_t  cfg,
  input  rbst_pkg::item_t d_in,
  output rbst_pkg::item_t d_out
);
  import rbst_pkg::*;

  item_t nxt;

  always_comb begin
    lane_t           ln;
    logic [QBits:0]  rs;
    logic [QBits:0]  dv;
    nxt = d_in;
    for (int j = 0; j < NumLanes; j++) begin
      ln = d_in.lane[j];
      rs = {ln.rem, ln.num[QBits-1]};
      dv = {1'b0, cfg.dmag[j%NumAxes]};
      if (rs >= dv) begin
        ln.rem = QBits'(rs - dv);
        ln.q   = {ln.q[QBits-2:0], 1'b1};
      end else begin
        ln.rem = rs[QBits-1:0];
        ln.q   = {ln.q[QBits-2:0], 1'b0};
      end
      ln.num = {ln.num[QBits-2:0], 1'b0};
      nxt.lane[j] = ln;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end
endmodule

// ----- design/rbst_resolve.sv -----
// Back stages: saturate quotients, entry/exit reduction, hit decision.
module rbst_resolve (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rbst_pkg::cfg_t  cfg,
  input  rbst_pkg::item_t d_in,
  output logic            out_valid,
  output logic            hit
);
  import rbst_pkg::*;

  logic                                    f1_valid, f1_miss;
  logic signed [NumAxes-1:0][WideW-1:0]    f1_near, f1_far;
  logic signed [NumAxes-1:0][WideW-1:0]    near_next, far_next;
  logic                                    f2_valid, f2_miss;
  logic signed [WideW-1:0]                 f2_entry, f2_exit;
  logic signed [WideW-1:0]                 entry_next, exit_next;
  logic                                    hit_next;

  // stage F1: signed, saturated slab distances, ordered near/far
  always_comb begin
    lane_t                   ln;
    logic signed [WideW-1:0] v [NumLanes];
    for (int j = 0; j < NumLanes; j++) begin
      ln = d_in.lane[j];
      if (!ln.neg) begin
        v[j] = (ln.ovf || ln.q[QBits-1]) ? QMax : $signed({2'b00, ln.q});
      end else begin
        v[j] = (ln.ovf || ln.q > 32'h8000_0000) ? QMin : -$signed({2'b00, ln.q});
      end
    end
    for (int a = 0; a < NumAxes; a++) begin
      if (cfg.dzero[a]) begin
        near_next[a] = NegUnbounded;
        far_next[a]  = PosUnbounded;
      end else if (cfg.dneg[a]) begin
        near_next[a] = v[a+NumAxes];
        far_next[a]  = v[a];
      end else begin
        near_next[a] = v[a];
        far_next[a]  = v[a+NumAxes];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= d_in.valid;
      f1_miss  <= d_in.miss;
      f1_near  <= near_next;
      f1_far   <= far_next;
    end
  end

  // stage F2: entry is the largest near, exit the smallest far
  // (elements of a packed array read back unsigned, so compare them as signed)
  always_comb begin
    entry_next = $signed(f1_near[0]);
    exit_next  = $signed(f1_far[0]);
    for (int a = 1; a < NumAxes; a++) begin
      if ($signed(f1_near[a]) > entry_next) entry_next = $signed(f1_near[a]);
      if ($signed(f1_far[a]) < exit_next)   exit_next  = $signed(f1_far[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
      f2_miss  <= f1_miss;
      f2_entry <= entry_next;
      f2_exit  <= exit_next;
    end
  end

  // stage F3: interval checks, output register
  assign hit_next = !f2_miss && (f2_entry < f2_exit) &&
                    (f2_entry <= $signed({{2{cfg.t_high[31]}}, cfg.t_high})) &&
                    (f2_exit  >= $signed({{2{cfg.t_low[31]}}, cfg.t_low}));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f2_valid;
      hit       <= hit_next;
    end
  end
endmodule

// ----- design/ray_box_slab_test.sv -----
// Top level of the ray versus axis-aligned box slab test.
// Tests one box per beat against the ray in the configuration registers and
// returns one hit bit per box, in order. A new box is taken every cycle while
// in_stall is low; there are 37 register stages: two setup stages, 32
// restoring-division stages (one quotient bit per stage for all six slab
// distances) and three stages for saturation, entry/exit and the interval
// checks. The whole pipeline holds while a result waits under out_stall.
// Write the ray registers only when no box is in flight.
module ray_box_slab_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] box_min_x,
  input  logic [31:0] box_min_y,
  input  logic [31:0] box_min_z,
  input  logic [31:0] box_max_x,
  input  logic [31:0] box_max_y,
  input  logic [31:0] box_max_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbst_pkg::*;

  cfg_t             cfg;
  logic             en;
  logic [5:0][31:0] corner;
  item_t            stage [DivSteps+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign corner   = {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x};

  rbst_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  rbst_prep u_prep (
    .clk, .rst, .en,
    .in_beat (in_valid),
    .corner,
    .cfg,
    .item    (stage[0])
  );

  // division chain
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    rbst_div_step u_step (
      .clk, .rst, .en, .cfg,
      .d_in  (stage[k]),
      .d_out (stage[k+1])
    );
  end

  rbst_resolve u_resolve (
    .clk, .rst, .en, .cfg,
    .d_in      (stage[DivSteps]),
    .out_valid,
    .hit
  );
endmodule
